// ----- sv/rsm_pkg.sv -----
// Shared constants, action codes and controller/datapath interface types of the mixer.
`timescale 1ns / 1ps
package rsm_pkg;

	localparam int NUM_SLOTS    = 4;
	localparam int SLOT_W       = 2;
	localparam int STORE_FRAMES = 4096;
	localparam int ADDR_W       = 12;

	// Reciprocal of 255 in Q31, rounded up; exact for quotients of values below 2^23.
	localparam logic [23:0] RECIP_255 = 24'd8421505;

	localparam logic [7:0] MASTER_RESET = 8'd200;

	typedef enum logic [2:0] {
		ACT_TICK   = 3'd0,
		ACT_LOAD   = 3'd1,
		ACT_OPEN   = 3'd2,
		ACT_PAUSE  = 3'd3,
		ACT_RESUME = 3'd4,
		ACT_CLOSE  = 3'd5
	} action_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              capture;
		logic              exec;
		logic              chk;
		logic              rd1;
		logic              mul1;
		logic              mul2;
		logic              mul3;
		logic              acc;
		logic              fin;
		logic              load_out;
		logic [SLOT_W-1:0] slot;
	} rsm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_tick;
		logic out_free;
	} rsm_sts_t;

endpackage

// ----- sv/rsm_ctrl.sv -----
// Controller state machine that sequences one item through the mixer datapath.
`timescale 1ns / 1ps
module rsm_ctrl import rsm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rsm_sts_t sts,
	output rsm_cmd_t cmd
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_EXEC = 10'b0000000010,
		ST_CHK  = 10'b0000000100,
		ST_RD1  = 10'b0000001000,
		ST_MUL1 = 10'b0000010000,
		ST_MUL2 = 10'b0000100000,
		ST_MUL3 = 10'b0001000000,
		ST_ACC  = 10'b0010000000,
		ST_FIN  = 10'b0100000000,
		ST_DONE = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic [SLOT_W-1:0] slot_q;

	assign in_ready = (state_q == ST_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_EXEC;
			ST_EXEC: state_d = sts.is_tick ? ST_CHK : ST_DONE;
			ST_CHK:  state_d = ST_RD1;
			ST_RD1:  state_d = ST_MUL1;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_MUL3;
			ST_MUL3: state_d = ST_ACC;
			ST_ACC:  state_d = (slot_q == SLOT_W'(NUM_SLOTS - 1)) ? ST_FIN : ST_CHK;
			ST_FIN:  state_d = ST_DONE;
			ST_DONE: if (sts.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// State and slot counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EXEC)
				slot_q <= '0;
			else if (state_q == ST_ACC)
				slot_q <= slot_q + SLOT_W'(1);
		end
	end

	// Command decode.
	always_comb begin
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.exec     = (state_q == ST_EXEC);
		cmd.chk      = (state_q == ST_CHK);
		cmd.rd1      = (state_q == ST_RD1);
		cmd.mul1     = (state_q == ST_MUL1);
		cmd.mul2     = (state_q == ST_MUL2);
		cmd.mul3     = (state_q == ST_MUL3);
		cmd.acc      = (state_q == ST_ACC);
		cmd.fin      = (state_q == ST_FIN);
		cmd.load_out = (state_q == ST_DONE) && sts.out_free;
		cmd.slot     = slot_q;
	end

endmodule

// ----- sv/rsm_dp.sv -----
// Datapath of the mixer: sample store, slot state, interpolation and mixing arithmetic.
`timescale 1ns / 1ps
module rsm_dp import rsm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  rsm_cmd_t           cmd,
	output rsm_sts_t           sts,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_data,
	input  logic [2:0]         action,
	input  logic [1:0]         slot,
	input  logic [11:0]        address,
	input  logic signed [15:0] left_in,
	input  logic signed [15:0] right_in,
	input  logic [12:0]        length,
	input  logic [17:0]        step_ratio,
	input  logic [7:0]         volume,
	input  logic               loop_flag,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] left_out,
	output logic signed [15:0] right_out,
	output logic [2:0]         open_slot,
	output logic [3:0]         active_mask
);

	// Item registers.
	logic [2:0]        act_q;
	logic [SLOT_W-1:0] sel_q;
	logic [ADDR_W-1:0] addr_q;
	logic [15:0]       l_q, r_q;
	logic [12:0]       len_q;
	logic [17:0]       ratio_q;
	logic [7:0]        vol_q;
	logic              loop_q;
	logic [7:0]        master_q;
	logic [2:0]        grant_q;

	// Slot state.
	logic [NUM_SLOTS-1:0] active_q, paused_q, sloop_q;
	logic [ADDR_W-1:0]    base_q  [NUM_SLOTS];
	logic [12:0]          slen_q  [NUM_SLOTS];
	logic [17:0]          sratio_q[NUM_SLOTS];
	logic [7:0]           gain_q  [NUM_SLOTS];
	logic [29:0]          phase_q [NUM_SLOTS];

	// Sample store.
	logic [31:0]       store_mem [STORE_FRAMES];
	logic [31:0]       rdata_q;
	logic [ADDR_W-1:0] rd_addr;

	// Per-slot pipeline.
	logic              live_q;
	logic [15:0]       fr_q;
	logic [ADDR_W-1:0] a1_q;
	logic [31:0]       w0_q;
	logic signed [33:0] dprod_l_s1, dprod_r_s1;
	logic signed [15:0] s0_l_s1, s0_r_s1;
	logic signed [42:0] gprod_l_s2, gprod_r_s2;
	logic [46:0]        rprod_l_s3, rprod_r_s3;
	logic               neg_l_s3, neg_r_s3;
	logic signed [18:0] acc_l_q, acc_r_q;
	logic signed [27:0] mix_l_q, mix_r_q;

	logic out_valid_q;

	assign sts.is_tick  = (act_q == ACT_TICK);
	assign sts.out_free = !out_valid_q || out_ready;

	// Slot evaluation at the start of its turn.
	logic [29:0] ph;
	logic [13:0] i0, i0e;
	logic [15:0] fr, fre;
	logic [12:0] slen;
	logic        over, wrap, kill, run;
	logic [14:0] i0p1;
	logic [12:0] lenm1;
	logic [11:0] i1;
	logic [ADDR_W-1:0] a0, a1;

	always_comb begin
		ph    = phase_q[cmd.slot];
		slen  = slen_q[cmd.slot];
		i0    = ph[29:16];
		fr    = ph[15:0];
		over  = i0 >= {1'b0, slen};
		wrap  = over && sloop_q[cmd.slot] && (slen != 13'd0);
		kill  = over && !wrap;
		run   = active_q[cmd.slot] && !paused_q[cmd.slot];
		i0e   = wrap ? 14'd0 : i0;
		fre   = wrap ? 16'd0 : fr;
		i0p1  = {1'b0, i0e} + 15'd1;
		lenm1 = slen - 13'd1;
		i1    = (i0p1 < {2'b00, slen}) ? i0p1[11:0] : lenm1[11:0];
		a0    = base_q[cmd.slot] + i0e[11:0];
		a1    = base_q[cmd.slot] + i1;
		rd_addr = cmd.rd1 ? a1_q : a0;
	end

	// Store write and registered read.
	always_ff @(posedge clk) begin
		if (cmd.exec && act_q == ACT_LOAD)
			store_mem[addr_q] <= {r_q, l_q};
		rdata_q <= store_mem[rd_addr];
	end

	// Item capture and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= ACT_TICK;
			master_q <= MASTER_RESET;
		end else begin
			if (cmd.capture)
				act_q <= action;
			if (cfg_we)
				master_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sel_q   <= slot;
			addr_q  <= address;
			l_q     <= left_in;
			r_q     <= right_in;
			len_q   <= length;
			ratio_q <= step_ratio;
			vol_q   <= volume;
			loop_q  <= loop_flag;
		end
	end

	// First free slot for an open.
	logic [2:0] free_idx;
	always_comb begin
		free_idx = 3'(NUM_SLOTS);
		for (int s = NUM_SLOTS - 1; s >= 0; s--)
			if (!active_q[s]) free_idx = 3'(s);
	end

	// Slot state updates from commands and the mixing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			paused_q <= '0;
			sloop_q  <= '0;
			grant_q  <= 3'(NUM_SLOTS);
			for (int s = 0; s < NUM_SLOTS; s++) begin
				base_q[s]   <= '0;
				slen_q[s]   <= '0;
				sratio_q[s] <= '0;
				gain_q[s]   <= '0;
				phase_q[s]  <= '0;
			end
		end else begin
			if (cmd.capture)
				grant_q <= 3'(NUM_SLOTS);
			if (cmd.exec) begin
				case (act_q)
					ACT_OPEN: begin
						if (free_idx != 3'(NUM_SLOTS)) begin
							base_q[free_idx[1:0]]   <= addr_q;
							slen_q[free_idx[1:0]]   <= len_q;
							sratio_q[free_idx[1:0]] <= ratio_q;
							gain_q[free_idx[1:0]]   <= vol_q;
							sloop_q[free_idx[1:0]]  <= loop_q;
							phase_q[free_idx[1:0]]  <= '0;
							paused_q[free_idx[1:0]] <= 1'b0;
							active_q[free_idx[1:0]] <= 1'b1;
						end
						grant_q <= free_idx;
					end
					ACT_PAUSE:  paused_q[sel_q] <= 1'b1;
					ACT_RESUME: paused_q[sel_q] <= 1'b0;
					ACT_CLOSE:  active_q[sel_q] <= 1'b0;
					default: ;
				endcase
			end
			if (cmd.chk && run) begin
				if (kill)
					active_q[cmd.slot] <= 1'b0;
				else
					phase_q[cmd.slot] <= (wrap ? 30'd0 : ph) + 30'(sratio_q[cmd.slot]);
			end
		end
	end

	// Interpolation and gain pipeline, both channels side by side.
	logic signed [15:0] s1_l, s1_r;
	logic signed [16:0] d_l, d_r;
	logic signed [33:0] q_l, q_r;
	logic [42:0]        m_l, m_r;
	logic [15:0]        v_l, v_r;
	logic signed [18:0] c_l, c_r;

	always_comb begin
		s1_l = rdata_q[15:0];
		s1_r = rdata_q[31:16];
		d_l  = 17'(s1_l) - 17'($signed(w0_q[15:0]));
		d_r  = 17'(s1_r) - 17'($signed(w0_q[31:16]));
		q_l  = ($signed(34'(s0_l_s1)) <<< 16) + dprod_l_s1;
		q_r  = ($signed(34'(s0_r_s1)) <<< 16) + dprod_r_s1;
		m_l  = gprod_l_s2[42] ? 43'(-gprod_l_s2) : 43'(gprod_l_s2);
		m_r  = gprod_r_s2[42] ? 43'(-gprod_r_s2) : 43'(gprod_r_s2);
		v_l  = rprod_l_s3[46:31];
		v_r  = rprod_r_s3[46:31];
		c_l  = neg_l_s3 ? -$signed({3'b000, v_l}) : $signed({3'b000, v_l});
		c_r  = neg_r_s3 ? -$signed({3'b000, v_r}) : $signed({3'b000, v_r});
	end

	always_ff @(posedge clk) begin
		if (cmd.chk) begin
			live_q <= run && !kill;
			fr_q   <= fre;
			a1_q   <= a1;
		end
		if (cmd.rd1)
			w0_q <= rdata_q;
		if (cmd.mul1) begin
			dprod_l_s1 <= d_l * $signed({1'b0, fr_q});
			dprod_r_s1 <= d_r * $signed({1'b0, fr_q});
			s0_l_s1    <= w0_q[15:0];
			s0_r_s1    <= w0_q[31:16];
		end
		if (cmd.mul2) begin
			gprod_l_s2 <= 43'(q_l) * $signed({1'b0, gain_q[cmd.slot]});
			gprod_r_s2 <= 43'(q_r) * $signed({1'b0, gain_q[cmd.slot]});
		end
		if (cmd.mul3) begin
			rprod_l_s3 <= m_l[38:16] * RECIP_255;
			rprod_r_s3 <= m_r[38:16] * RECIP_255;
			neg_l_s3   <= gprod_l_s2[42];
			neg_r_s3   <= gprod_r_s2[42];
		end
	end

	// Mix accumulation and master gain.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			acc_l_q <= '0;
			acc_r_q <= '0;
			mix_l_q <= '0;
			mix_r_q <= '0;
		end else begin
			if (cmd.acc && live_q) begin
				acc_l_q <= acc_l_q + c_l;
				acc_r_q <= acc_r_q + c_r;
			end
			if (cmd.fin) begin
				mix_l_q <= 28'(acc_l_q) * $signed({1'b0, master_q});
				mix_r_q <= 28'(acc_r_q) * $signed({1'b0, master_q});
			end
		end
	end

	// Floor shift by eight and saturation.
	logic signed [19:0] sh_l, sh_r;
	logic signed [15:0] sat_l, sat_r;
	always_comb begin
		sh_l = 20'(mix_l_q >>> 8);
		sh_r = 20'(mix_r_q >>> 8);
		if (sh_l > 20'sd32767)       sat_l = 16'sh7FFF;
		else if (sh_l < -20'sd32768) sat_l = 16'sh8000;
		else                         sat_l = sh_l[15:0];
		if (sh_r > 20'sd32767)       sat_r = 16'sh7FFF;
		else if (sh_r < -20'sd32768) sat_r = 16'sh8000;
		else                         sat_r = sh_r[15:0];
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			left_out    <= sat_l;
			right_out   <= sat_r;
			open_slot   <= grant_q;
			active_mask <= active_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- sv/resampling_stereo_mixer.sv -----
// Top level of the four-slot resampling stereo mixer.
// Each item is taken alone. A tick walks the four slots one after another (for each slot
// two reads of the single-port sample store, then three multiplier stages and an
// accumulate); load, open, pause, resume and close items skip this walk. The next item
// is accepted in the cycle after the one that places the result in the output
// register. Memory contents are undefined after reset, so a stream must only cover
// frames that were loaded.
`timescale 1ns / 1ps
module resampling_stereo_mixer import rsm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         action,
	input  logic [1:0]         slot,
	input  logic [11:0]        address,
	input  logic signed [15:0] left_in,
	input  logic signed [15:0] right_in,
	input  logic [12:0]        length,
	input  logic [17:0]        step_ratio,
	input  logic [7:0]         volume,
	input  logic               loop_flag,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] left_out,
	output logic signed [15:0] right_out,
	output logic [2:0]         open_slot,
	output logic [3:0]         active_mask
);

	rsm_cmd_t cmd;
	rsm_sts_t sts;

	// Sequencer.
	rsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Store, slot state and arithmetic.
	rsm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.action      (action),
		.slot        (slot),
		.address     (address),
		.left_in     (left_in),
		.right_in    (right_in),
		.length      (length),
		.step_ratio  (step_ratio),
		.volume      (volume),
		.loop_flag   (loop_flag),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.left_out    (left_out),
		.right_out   (right_out),
		.open_slot   (open_slot),
		.active_mask (active_mask)
	);

`ifndef ASSERT_OFF
	// A new result only appears while the block is busy with an item.
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without an item in flight");

	// A granted slot is active in the same result.
	a_grant_active: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && open_slot != 3'(NUM_SLOTS)) |-> active_mask[open_slot[1:0]])
		else $error("granted slot not active");

	// The block takes no item while a result is being loaded.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !in_ready)
		else $error("item accepted during result load");
`endif

endmodule

// ----- bench/resampling_stereo_mixer_tb.sv -----
// Self-checking testbench for the four-slot resampling stereo mixer.
`timescale 1ns / 1ps
module resampling_stereo_mixer_tb;
	import rsm_pkg::*;

	// Action codes that the block must ignore.
	localparam logic [2:0] ACT_SPARE_LO = 3'd6;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;

	typedef struct {
		logic [2:0]  action;
		logic [1:0]  slot;
		logic [11:0] address;
		logic [15:0] left_in;
		logic [15:0] right_in;
		logic [12:0] length;
		logic [17:0] step_ratio;
		logic [7:0]  volume;
		logic        loop_flag;
	} mix_cmd_t;

	typedef struct {
		logic [15:0] left_out;
		logic [15:0] right_out;
		logic [2:0]  open_slot;
		logic [3:0]  active_mask;
	} mix_frame_t;

	// Mixer predictor and store of expected frames.
	class mixer_scoreboard;
		logic [31:0] store [STORE_FRAMES];
		bit          written [STORE_FRAMES];
		bit          act [NUM_SLOTS];
		bit          paused [NUM_SLOTS];
		bit          wrap [NUM_SLOTS];
		logic [11:0] base [NUM_SLOTS];
		logic [12:0] len [NUM_SLOTS];
		logic [17:0] ratio [NUM_SLOTS];
		logic [7:0]  gain [NUM_SLOTS];
		logic [29:0] phase [NUM_SLOTS];
		logic [7:0]  master = MASTER_RESET;
		mix_frame_t  expected_frames [$];
		int          errors = 0;
		int          ticks = 0;
		int          grants = 0;
		int          last_grant = NUM_SLOTS;

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
			errors++;
		endtask

		function longint lerp(logic [15:0] a, logic [15:0] b, logic [15:0] fr, logic [7:0] g);
			longint s0, s1, q;
			s0 = longint'($signed(a));
			s1 = longint'($signed(b));
			q = s0 * 65536 + (s1 - s0) * longint'(fr);
			return (q * longint'(g)) / longint'(255 * 65536);
		endfunction

		function logic [15:0] clip16(longint v);
			if (v > 32767)
				return 16'h7fff;
			if (v < -32768)
				return 16'h8000;
			return v[15:0];
		endfunction

		// True when every frame of a stream has been loaded.
		function bit covered(logic [11:0] b, logic [12:0] l);
			for (int k = 0; k < l; k++)
				if (!written[(b + k) % STORE_FRAMES])
					return 0;
			return 1;
		endfunction

		// A tick may only read loaded frames.
		function bit slot_safe(int s);
			return !act[s] || covered(base[s], len[s]);
		endfunction

		function void note_input(mix_cmd_t c);
			mix_frame_t f;
			longint mix_l, mix_r;
			int i0, i1;
			logic [15:0] fr;
			logic [31:0] w0, w1;
			f.left_out = 0;
			f.right_out = 0;
			f.open_slot = NUM_SLOTS;
			mix_l = 0;
			mix_r = 0;
			last_grant = NUM_SLOTS;
			case (c.action)
				ACT_TICK: begin
					ticks++;
					for (int s = 0; s < NUM_SLOTS; s++) begin
						if (!act[s] || paused[s])
							continue;
						i0 = phase[s][29:16];
						fr = phase[s][15:0];
						if (i0 >= len[s]) begin
							if (wrap[s] && len[s] > 0) begin
								phase[s] = 0;
								i0 = 0;
								fr = 0;
							end else begin
								act[s] = 0;
								continue;
							end
						end
						i1 = (i0 + 1 < len[s]) ? i0 + 1 : len[s] - 1;
						w0 = store[(base[s] + i0) % STORE_FRAMES];
						w1 = store[(base[s] + i1) % STORE_FRAMES];
						mix_l += lerp(w0[15:0], w1[15:0], fr, gain[s]);
						mix_r += lerp(w0[31:16], w1[31:16], fr, gain[s]);
						phase[s] = phase[s] + ratio[s];
					end
					f.left_out = clip16((mix_l * longint'(master)) >>> 8);
					f.right_out = clip16((mix_r * longint'(master)) >>> 8);
				end
				ACT_LOAD: begin
					store[c.address] = {c.right_in, c.left_in};
					written[c.address] = 1;
				end
				ACT_OPEN: begin
					for (int s = 0; s < NUM_SLOTS; s++) begin
						if (!act[s]) begin
							base[s] = c.address;
							len[s] = c.length;
							ratio[s] = c.step_ratio;
							gain[s] = c.volume;
							wrap[s] = c.loop_flag;
							phase[s] = 0;
							paused[s] = 0;
							act[s] = 1;
							f.open_slot = s;
							last_grant = s;
							grants++;
							break;
						end
					end
				end
				ACT_PAUSE: paused[c.slot] = 1;
				ACT_RESUME: paused[c.slot] = 0;
				ACT_CLOSE: act[c.slot] = 0;
				default: ;
			endcase
			f.active_mask = {act[3], act[2], act[1], act[0]};
			expected_frames.push_back(f);
		endfunction

		task check(mix_frame_t got);
			mix_frame_t want;
			if (expected_frames.size() == 0) begin
				report("unexpected frame", got.active_mask, 0);
				return;
			end
			want = expected_frames.pop_front();
			if (got.left_out !== want.left_out)
				report("left_out", got.left_out, want.left_out);
			if (got.right_out !== want.right_out)
				report("right_out", got.right_out, want.right_out);
			if (got.open_slot !== want.open_slot)
				report("open_slot", got.open_slot, want.open_slot);
			if (got.active_mask !== want.active_mask)
				report("active_mask", got.active_mask, want.active_mask);
		endtask
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic [7:0]         cfg_data = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [2:0]         action = 0;
	logic [1:0]         slot = 0;
	logic [11:0]        address = 0;
	logic signed [15:0] left_in = 0;
	logic signed [15:0] right_in = 0;
	logic [12:0]        length = 0;
	logic [17:0]        step_ratio = 0;
	logic [7:0]         volume = 0;
	logic               loop_flag = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;
	logic [2:0]         open_slot;
	logic [3:0]         active_mask;

	mixer_scoreboard mix_sb = new();
	bit idling = 1;
	int sent = 0;

	resampling_stereo_mixer uut (.*);

	always #6 clk = ~clk;

	// Hard stop in case the block hangs.
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	// Result side: random stalls, sampling at the falling edge.
	initial begin
		mix_frame_t got;
		bit taken;
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			taken = out_valid && out_ready;
			got.left_out = left_out;
			got.right_out = right_out;
			got.open_slot = open_slot;
			got.active_mask = active_mask;
			@(posedge clk);
			if (taken)
				mix_sb.check(got);
			if (stall == 0 && idling && $urandom_range(0, 15) == 0)
				stall = $urandom_range(1, 16);
			if (stall > 0) begin
				out_ready <= 0;
				stall--;
			end else begin
				out_ready <= 1;
			end
		end
	end

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'hffff;
			default: return $urandom;
		endcase
	endfunction

	// Random item; callers fix the fields that matter.
	function automatic mix_cmd_t any_cmd(logic [2:0] a);
		mix_cmd_t c;
		c.action = a;
		c.slot = $urandom;
		c.address = $urandom;
		c.left_in = pick_sample();
		c.right_in = pick_sample();
		c.length = $urandom;
		c.step_ratio = $urandom;
		c.volume = $urandom;
		c.loop_flag = $urandom;
		return c;
	endfunction

	// Offer one item, hold it until accepted, then predict its frame.
	task send_item(mix_cmd_t c);
		bit ready_seen;
		if (idling && $urandom_range(0, 7) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		action <= c.action;
		slot <= c.slot;
		address <= c.address;
		left_in <= c.left_in;
		right_in <= c.right_in;
		length <= c.length;
		step_ratio <= c.step_ratio;
		volume <= c.volume;
		loop_flag <= c.loop_flag;
		in_valid <= 1;
		do begin
			@(negedge clk);
			ready_seen = in_ready;
			@(posedge clk);
		end while (!ready_seen);
		mix_sb.note_input(c);
		sent++;
	endtask

	task load_frame(logic [11:0] a, logic [15:0] l, logic [15:0] r);
		mix_cmd_t c;
		c = any_cmd(ACT_LOAD);
		c.address = a;
		c.left_in = l;
		c.right_in = r;
		send_item(c);
	endtask

	// Open a stream; if it covers unloaded frames the granted slot is closed at once.
	task open_stream(logic [11:0] a, logic [12:0] l, logic [17:0] st, logic [7:0] g, logic lp);
		mix_cmd_t c;
		int s;
		c = any_cmd(ACT_OPEN);
		c.address = a;
		c.length = l;
		c.step_ratio = st;
		c.volume = g;
		c.loop_flag = lp;
		send_item(c);
		s = mix_sb.last_grant;
		if (s < NUM_SLOTS && !mix_sb.covered(a, l))
			slot_cmd(ACT_CLOSE, s);
	endtask

	task slot_cmd(logic [2:0] a, int s);
		mix_cmd_t c;
		c = any_cmd(a);
		c.slot = s;
		send_item(c);
	endtask

	// Write the master gain once every pending frame is out and the block is idle.
	task tune_master(logic [7:0] v);
		in_valid <= 0;
		while (mix_sb.expected_frames.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		mix_sb.master = v;
	endtask

	task run_random(int count);
		int stop_at, r, s, n;
		logic [11:0] b;
		stop_at = sent + count;
		while (sent < stop_at) begin
			r = $urandom_range(0, 99);
			s = $urandom_range(0, NUM_SLOTS - 1);
			if (r < 8) begin
				// Well-formed stream: load a run of frames, then play it.
				b = $urandom;
				n = $urandom_range(1, 12);
				for (int k = 0; k < n; k++)
					load_frame(b + k, pick_sample(), pick_sample());
				open_stream(b, ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n,
					($urandom_range(0, 1) == 0) ? $urandom_range(0, 18'h20000) : $urandom,
					$urandom, $urandom);
			end else if (r < 50) begin
				for (int k = 0; k < NUM_SLOTS; k++)
					if (!mix_sb.slot_safe(k))
						slot_cmd(ACT_CLOSE, k);
				send_item(any_cmd(ACT_TICK));
			end else if (r < 58) begin
				load_frame($urandom, pick_sample(), pick_sample());
			end else if (r < 66) begin
				open_stream($urandom,
					($urandom_range(0, 1) == 0) ? $urandom_range(0, 16) : $urandom,
					$urandom, $urandom, $urandom);
			end else if (r < 74) begin
				slot_cmd(ACT_PAUSE, s);
			end else if (r < 82) begin
				slot_cmd(mix_sb.slot_safe(s) ? ACT_RESUME : ACT_CLOSE, s);
			end else if (r < 88) begin
				slot_cmd(ACT_CLOSE, s);
			end else if (r < 91) begin
				send_item(any_cmd($urandom_range(0, 1) ? ACT_SPARE_LO : ACT_SPARE_HI));
			end else begin
				send_item(any_cmd(ACT_TICK));
			end
		end
	endtask

	// Stimulus and end of run.
	initial begin
		int guard;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, store wrap, loop wrap, zero length, full slots, ignored codes.
		load_frame(12'd4095, 16'h7fff, 16'h8000);
		load_frame(12'd0, 16'h8000, 16'h7fff);
		load_frame(12'd1, 16'd100, 16'hff9c);
		open_stream(12'd4095, 13'd3, 18'h08000, 8'd255, 1'b1);
		repeat (7) send_item(any_cmd(ACT_TICK));
		open_stream(12'd0, 13'd0, 18'h3ffff, 8'd0, 1'b1);
		send_item(any_cmd(ACT_TICK));
		open_stream(12'd0, 13'd4096, 18'h3ffff, 8'd255, 1'b0);
		slot_cmd(ACT_PAUSE, 0);
		send_item(any_cmd(ACT_TICK));
		slot_cmd(ACT_RESUME, 0);
		open_stream(12'd0, 13'd1, 18'h10000, 8'd128, 1'b0);
		open_stream(12'd1, 13'd1, 18'h10000, 8'd255, 1'b0);
		open_stream(12'd0, 13'd2, 18'h00001, 8'd255, 1'b1);
		open_stream(12'd0, 13'd1, 18'h10000, 8'd255, 1'b0);
		send_item(any_cmd(ACT_TICK));
		send_item(any_cmd(ACT_TICK));
		send_item(any_cmd(ACT_SPARE_LO));
		send_item(any_cmd(ACT_SPARE_HI));
		slot_cmd(ACT_CLOSE, 3);
		slot_cmd(ACT_PAUSE, 3);

		// Random phases over several master gains; the last one runs without idling.
		tune_master(8'd0);
		run_random(200);
		tune_master(8'd255);
		run_random(400);
		tune_master(8'd1);
		run_random(200);
		tune_master($urandom);
		run_random(500);
		tune_master(8'd128);
		idling = 0;
		run_random(620);
		in_valid <= 0;

		guard = 0;
		while (mix_sb.expected_frames.size() > 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
		if (mix_sb.expected_frames.size() > 0)
			mix_sb.report("frames never delivered", mix_sb.expected_frames.size(), 0);
		$display("Covered %0d items: %0d ticks, %0d granted opens, six master gain settings.",
			sent, mix_sb.ticks, mix_sb.grants);
		if (mix_sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
sv/rsm_pkg.sv
sv/rsm_ctrl.sv
sv/rsm_dp.sv
sv/resampling_stereo_mixer.sv
bench/resampling_stereo_mixer_tb.sv
